FILE: rtl/mhpq_pkg.sv
// Package for the binary max-heap priority queue.
// Transaction structs, field widths, operation and status codes.
// No dependencies.
package mhpq_pkg;

  localparam int KEY_W         = 32;
  localparam int CNT_W         = 5;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                    func;
    logic signed [KEY_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] popped_value;
    logic [STATUS_W-1:0]     status;
    logic [CNT_W-1:0]        count;
  } out_t;

endpackage

FILE: rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue: top level with heap store and sift sequencer.
// Depends on mhpq_pkg.
//
// Each input transaction is an insert of a signed 32-bit key or a pop of the
// largest key, and yields exactly one result with the popped key, a status and
// the entry count afterwards. The heap lives in a single memory with one read
// and one write port, read data registered; one comparator walks the tree one
// level at a time. A dropped insert or an empty pop goes straight to its
// result; an insert sifts the new key up and a pop moves the last key to the
// root and sifts it down, comparing it with the larger child at each level.
// A result waits while the output register still holds an untaken result. The
// input stalls until the result is handed to the output register, which may
// still hold an untaken result while the next transaction is accepted.
// Capacity is clamped to DEPTH and to 31 and should be written while the
// queue is idle.
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int AW      = $clog2(DEPTH);
  localparam int LIM_MAX = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM_MAX);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_UP   = 4'd1;
  localparam logic [3:0] S_UPC  = 4'd2;
  localparam logic [3:0] S_POPL = 4'd3;
  localparam logic [3:0] S_POPC = 4'd4;
  localparam logic [3:0] S_DN   = 4'd5;
  localparam logic [3:0] S_DNR  = 4'd6;
  localparam logic [3:0] S_DNRR = 4'd7;
  localparam logic [3:0] S_DNC  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  function automatic logic [AW-1:0] to_idx(input logic [CNT_W:0] p);
    logic [AW+CNT_W:0] w;
    w = {{AW{1'b0}}, p};
    return w[AW-1:0];
  endfunction

  logic signed [KEY_W-1:0] mem [DEPTH];

  logic [3:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        cap_r;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        big_pos_r, big_pos_nxt;
  logic signed [KEY_W-1:0] cur_r, cur_nxt;
  logic signed [KEY_W-1:0] big_val_r, big_val_nxt;
  logic signed [KEY_W-1:0] popped_r, popped_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  logic signed [KEY_W-1:0] rd_data_r;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_r, out_nxt;

  logic [AW-1:0]           rd_addr;
  logic                    we;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;

  logic [CNT_W-1:0]        limit;
  logic                    in_acc;
  logic [CNT_W-1:0]        parent;
  logic [CNT_W:0]          lchild;
  logic [CNT_W:0]          rchild;
  logic                    r_ok;

  assign limit     = (cap_r > LIM_C) ? LIM_C : cap_r;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign parent = (pos_r - CNT_W'(1)) >> 1;
  assign lchild = {pos_r, 1'b1};
  assign rchild = lchild + (CNT_W+1)'(1);
  assign r_ok   = rchild < {1'b0, cnt_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    big_pos_nxt   = big_pos_r;
    cur_nxt       = cur_r;
    big_val_nxt   = big_val_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    rd_addr       = '0;
    we            = 1'b0;
    wr_addr       = to_idx({1'b0, pos_r});
    wr_data       = cur_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          popped_nxt = '0;
          status_nxt = ST_OK;
          if (in_data.func == FUNC_INSERT) begin
            if (cnt_r >= limit) begin
              status_nxt = ST_FULL;
              state_nxt  = S_OUT;
            end else begin
              cur_nxt   = in_data.value;
              pos_nxt   = cnt_r;
              cnt_nxt   = cnt_r + CNT_W'(1);
              state_nxt = S_UP;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_OUT;
            end else begin
              state_nxt = S_POPL;
            end
          end
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_OUT;
        end else begin
          rd_addr   = to_idx({1'b0, parent});
          state_nxt = S_UPC;
        end
      end
      S_UPC: begin
        we = 1'b1;
        if (rd_data_r < cur_r) begin
          wr_data   = rd_data_r;
          pos_nxt   = parent;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_POPL: begin
        popped_nxt = rd_data_r;
        rd_addr    = to_idx({1'b0, cnt_r - CNT_W'(1)});
        state_nxt  = S_POPC;
      end
      S_POPC: begin
        cur_nxt   = rd_data_r;
        cnt_nxt   = cnt_r - CNT_W'(1);
        pos_nxt   = '0;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (lchild >= {1'b0, cnt_r}) begin
          we        = 1'b1;
          state_nxt = S_OUT;
        end else begin
          rd_addr   = to_idx(lchild);
          state_nxt = S_DNR;
        end
      end
      S_DNR: begin
        big_val_nxt = rd_data_r;
        big_pos_nxt = lchild[CNT_W-1:0];
        if (r_ok) begin
          rd_addr   = to_idx(rchild);
          state_nxt = S_DNRR;
        end else begin
          state_nxt = S_DNC;
        end
      end
      S_DNRR: begin
        if (big_val_r < rd_data_r) begin
          big_val_nxt = rd_data_r;
          big_pos_nxt = rchild[CNT_W-1:0];
        end
        state_nxt = S_DNC;
      end
      S_DNC: begin
        we = 1'b1;
        if (cur_r < big_val_r) begin
          wr_data   = big_val_r;
          pos_nxt   = big_pos_r;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.popped_value = popped_r;
          out_nxt.status       = status_r;
          out_nxt.count        = cnt_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    big_pos_r <= big_pos_nxt;
    cur_r     <= cur_nxt;
    big_val_r <= big_val_nxt;
    popped_r  <= popped_nxt;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LIM_C)
    else $error("entry count above limit");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.func == FUNC_INSERT && cnt_r < limit)
      |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("accepted insert did not grow the heap");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.func == FUNC_POP && cnt_r != '0)
      |=> ##2 (cnt_r == $past(cnt_r, 3) - CNT_W'(1)))
    else $error("accepted pop did not shrink the heap");

  a_up_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP || state_r == S_UPC) |-> (pos_r < cnt_r))
    else $error("sift-up position outside the heap");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && status_r != ST_OK) |-> (popped_r == '0))
    else $error("failed transaction carries a popped key");

endmodule
